// ===== src/sioc_pkg.sv =====
// Package for the sorted interval overlap checker.
// Holds request codes, controller states, command/status structs and defaults.
// No dependencies.
package sioc_pkg;

  localparam int MAX_INTERVALS_DEF = 64;
  localparam int TIME_BITS_DEF     = 16;
  localparam int COUNT_OUT_W       = 7;

  typedef enum logic [1:0] {
    REQ_LOAD_A = 2'd0,
    REQ_LOAD_B = 2'd1,
    REQ_CLEAR  = 2'd2,
    REQ_QUERY  = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LD_CHK,
    ST_INS_RD,
    ST_INS_CMP,
    ST_QRY_RD,
    ST_QRY_CMP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic clear;
    logic drop;
    logic rd_ins;
    logic shift;
    logic place;
    logic rd_qry;
    logic step;
    logic hit;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic ptr_zero;
    logic key_after;
    logic q_end;
    logic q_overlap;
  } sts_t;

endpackage

// ===== src/sorted_interval_overlap_check.sv =====
// Top level of the sorted interval overlap checker.
// Joins sioc_ctrl and sioc_dp. Depends on sioc_pkg, sioc_ctrl, sioc_dp.
//
// Usage: a transaction is taken at a rising edge with start high and busy low.
// req_type selects load into group A, load into group B, clear both, or query;
// start_time and end_time matter for loads only. Each transaction yields one
// result, shown for exactly one cycle with done high: overlap_found, status
// (full-group drop), count_a and count_b. busy stays high from the cycle after
// acceptance up to and including the done cycle, so the next transaction can
// be taken the cycle after done.
// Flow: a clear goes straight to done; a load first checks for a full group
// (dropped if full), then shifts stored entries that sort after the new one up
// one place at a time and places it; a query walks both groups, comparing at
// most 2*MAX_INTERVALS-1 pairs, and stops at the first overlap or at the end of
// either group. Each insert shift and each walk step passes a read state and
// then a compare/write state, as the read port of each store is registered.
// Reset empties both groups and returns to idle; stored entries are not
// cleared. The receiver cannot stall; results must be taken on done.
module sorted_interval_overlap_check #(
  parameter int MAX_INTERVALS = sioc_pkg::MAX_INTERVALS_DEF,
  parameter int TIME_BITS     = sioc_pkg::TIME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           req_type,
  input  logic [TIME_BITS-1:0] start_time,
  input  logic [TIME_BITS-1:0] end_time,
  output logic                 done,
  output logic                 overlap_found,
  output logic                 status,
  output logic [sioc_pkg::COUNT_OUT_W-1:0] count_a,
  output logic [sioc_pkg::COUNT_OUT_W-1:0] count_b
);

  sioc_pkg::cmd_t cmd;
  sioc_pkg::sts_t sts;
  logic           busy_int;

  sioc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (req_type),
    .sts      (sts),
    .cmd      (cmd),
    .busy     (busy_int),
    .done     (done)
  );

  sioc_dp #(
    .MAX_INTERVALS (MAX_INTERVALS),
    .TIME_BITS     (TIME_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .req_type      (req_type),
    .start_time    (start_time),
    .end_time      (end_time),
    .cmd           (cmd),
    .sts           (sts),
    .overlap_found (overlap_found),
    .status        (status),
    .count_a       (count_a),
    .count_b       (count_b)
  );

  assign busy = busy_int;

endmodule

// ===== src/sioc_ctrl.sv =====
// Sequencing state machine for the sorted interval overlap checker.
// Issues commands to sioc_dp and reacts to its status. Depends on sioc_pkg.
module sioc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [1:0]         req_type,
  input  sioc_pkg::sts_t     sts,
  output sioc_pkg::cmd_t     cmd,
  output logic               busy,
  output logic               done
);

  sioc_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sioc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      sioc_pkg::ST_IDLE: begin
        if (start) begin
          case (req_type)
            sioc_pkg::REQ_LOAD_A, sioc_pkg::REQ_LOAD_B: state_next = sioc_pkg::ST_LD_CHK;
            sioc_pkg::REQ_CLEAR:                        state_next = sioc_pkg::ST_DONE;
            default:                                    state_next = sioc_pkg::ST_QRY_RD;
          endcase
        end
      end
      sioc_pkg::ST_LD_CHK: begin
        state_next = sts.full ? sioc_pkg::ST_DONE : sioc_pkg::ST_INS_RD;
      end
      sioc_pkg::ST_INS_RD: begin
        state_next = sts.ptr_zero ? sioc_pkg::ST_DONE : sioc_pkg::ST_INS_CMP;
      end
      sioc_pkg::ST_INS_CMP: begin
        state_next = sts.key_after ? sioc_pkg::ST_INS_RD : sioc_pkg::ST_DONE;
      end
      sioc_pkg::ST_QRY_RD: begin
        state_next = sts.q_end ? sioc_pkg::ST_DONE : sioc_pkg::ST_QRY_CMP;
      end
      sioc_pkg::ST_QRY_CMP: begin
        state_next = sts.q_overlap ? sioc_pkg::ST_DONE : sioc_pkg::ST_QRY_RD;
      end
      sioc_pkg::ST_DONE: begin
        state_next = sioc_pkg::ST_IDLE;
      end
      default: begin
        state_next = sioc_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = (state != sioc_pkg::ST_IDLE);
    done = 1'b0;
    case (state)
      sioc_pkg::ST_IDLE: begin
        cmd.capture = start;
        cmd.clear   = start && (req_type == sioc_pkg::REQ_CLEAR);
      end
      sioc_pkg::ST_LD_CHK: begin
        cmd.drop = sts.full;
      end
      sioc_pkg::ST_INS_RD: begin
        cmd.place  = sts.ptr_zero;
        cmd.rd_ins = !sts.ptr_zero;
      end
      sioc_pkg::ST_INS_CMP: begin
        cmd.shift = sts.key_after;
        cmd.place = !sts.key_after;
      end
      sioc_pkg::ST_QRY_RD: begin
        cmd.rd_qry = !sts.q_end;
      end
      sioc_pkg::ST_QRY_CMP: begin
        cmd.hit  = sts.q_overlap;
        cmd.step = !sts.q_overlap;
      end
      sioc_pkg::ST_DONE: begin
        done = 1'b1;
      end
      default: begin
        done = 1'b0;
      end
    endcase
  end

endmodule

// ===== src/sioc_dp.sv =====
// Datapath for the sorted interval overlap checker: both interval stores,
// counts, insert pointer, walk pointers and result registers. Depends on sioc_pkg.
module sioc_dp #(
  parameter int MAX_INTERVALS = sioc_pkg::MAX_INTERVALS_DEF,
  parameter int TIME_BITS     = sioc_pkg::TIME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [1:0]           req_type,
  input  logic [TIME_BITS-1:0] start_time,
  input  logic [TIME_BITS-1:0] end_time,
  input  sioc_pkg::cmd_t       cmd,
  output sioc_pkg::sts_t       sts,
  output logic                 overlap_found,
  output logic                 status,
  output logic [sioc_pkg::COUNT_OUT_W-1:0] count_a,
  output logic [sioc_pkg::COUNT_OUT_W-1:0] count_b
);

  localparam int CW = $clog2(MAX_INTERVALS + 1);
  localparam int AW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
  localparam int EW = 2 * TIME_BITS;

  logic [EW-1:0] mem_a [MAX_INTERVALS];
  logic [EW-1:0] mem_b [MAX_INTERVALS];

  logic [CW-1:0] cnt_a, cnt_b;
  logic [CW-1:0] ptr, ia, ib;
  logic [EW-1:0] item;
  logic          sel_b;
  logic [EW-1:0] rd_a, rd_b;
  logic          found;
  logic          dropped;

  logic [CW-1:0] cnt_sel;
  logic [AW-1:0] ins_addr, addr_a, addr_b, wr_addr;
  logic [EW-1:0] wr_data, rd_sel;
  logic          we_a, we_b, rd_en;
  logic [TIME_BITS-1:0] a_s, a_e, b_s, b_e, r_s, r_e, i_s, i_e;

  assign cnt_sel  = sel_b ? cnt_b : cnt_a;
  assign ins_addr = AW'(ptr - CW'(1));
  assign addr_a   = cmd.rd_qry ? AW'(ia) : ins_addr;
  assign addr_b   = cmd.rd_qry ? AW'(ib) : ins_addr;
  assign wr_addr  = AW'(ptr);
  assign rd_sel   = sel_b ? rd_b : rd_a;
  assign wr_data  = cmd.shift ? rd_sel : item;
  assign we_a     = (cmd.shift || cmd.place) && !sel_b;
  assign we_b     = (cmd.shift || cmd.place) && sel_b;
  assign rd_en    = cmd.rd_ins || cmd.rd_qry;

  assign a_s = rd_a[EW-1:TIME_BITS];
  assign a_e = rd_a[TIME_BITS-1:0];
  assign b_s = rd_b[EW-1:TIME_BITS];
  assign b_e = rd_b[TIME_BITS-1:0];
  assign r_s = rd_sel[EW-1:TIME_BITS];
  assign r_e = rd_sel[TIME_BITS-1:0];
  assign i_s = item[EW-1:TIME_BITS];
  assign i_e = item[TIME_BITS-1:0];

  always_comb begin
    sts           = '0;
    sts.full      = (cnt_sel == CW'(MAX_INTERVALS));
    sts.ptr_zero  = (ptr == '0);
    sts.key_after = (r_s > i_s) || ((r_s == i_s) && (r_e > i_e));
    sts.q_end     = (ia >= cnt_a) || (ib >= cnt_b);
    sts.q_overlap = !((a_e <= b_s) || (a_s >= b_e));
  end

  always_ff @(posedge clk) begin
    if (we_a) begin
      mem_a[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_a <= mem_a[addr_a];
    end
  end

  always_ff @(posedge clk) begin
    if (we_b) begin
      mem_b[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_b <= mem_b[addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_a <= '0;
      cnt_b <= '0;
    end else if (cmd.clear) begin
      cnt_a <= '0;
      cnt_b <= '0;
    end else if (cmd.place) begin
      if (sel_b) begin
        cnt_b <= cnt_b + CW'(1);
      end else begin
        cnt_a <= cnt_a + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found   <= 1'b0;
      dropped <= 1'b0;
    end else if (cmd.capture) begin
      found   <= 1'b0;
      dropped <= 1'b0;
    end else begin
      if (cmd.hit) begin
        found <= 1'b1;
      end
      if (cmd.drop) begin
        dropped <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item  <= {start_time, end_time};
      sel_b <= (req_type == sioc_pkg::REQ_LOAD_B);
      ptr   <= (req_type == sioc_pkg::REQ_LOAD_B) ? cnt_b : cnt_a;
      ia    <= '0;
      ib    <= '0;
    end else begin
      if (cmd.shift) begin
        ptr <= ptr - CW'(1);
      end
      if (cmd.step) begin
        if (a_s > b_s) begin
          ib <= ib + CW'(1);
        end else begin
          ia <= ia + CW'(1);
        end
      end
    end
  end

  assign overlap_found = found;
  assign status        = dropped;
  assign count_a       = sioc_pkg::COUNT_OUT_W'(cnt_a);
  assign count_b       = sioc_pkg::COUNT_OUT_W'(cnt_b);

endmodule

// ===== sim/sorted_interval_overlap_check_test.sv =====
// Testbench for sorted_interval_overlap_check: directed and random transactions
// checked against a behavioural model of the two sorted interval groups.
// Depends on sioc_pkg and sorted_interval_overlap_check.
module sorted_interval_overlap_check_test;

  localparam int TW          = sioc_pkg::TIME_BITS_DEF;
  localparam int DEPTH       = sioc_pkg::MAX_INTERVALS_DEF;
  localparam int CW          = sioc_pkg::COUNT_OUT_W;
  localparam int CYCLE_LIMIT = 1_200_000;
  localparam int TAIL_CYCLES = 300;

  typedef struct packed {
    logic [TW-1:0] s;
    logic [TW-1:0] e;
  } span_t;

  typedef struct {
    logic          hit;
    logic          dropped;
    logic [CW-1:0] na;
    logic [CW-1:0] nb;
  } outcome_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          start = 1'b0;
  logic [1:0]    req_type = sioc_pkg::REQ_CLEAR;
  logic [TW-1:0] start_time = '0;
  logic [TW-1:0] end_time = '0;
  logic          busy;
  logic          done;
  logic          overlap_found;
  logic          status;
  logic [CW-1:0] count_a;
  logic [CW-1:0] count_b;

  span_t       a_spans[DEPTH];
  span_t       b_spans[DEPTH];
  int unsigned a_len = 0;
  int unsigned b_len = 0;

  outcome_t    outcome_q[$];
  int unsigned err_count = 0;
  int unsigned items_sent = 0;
  int unsigned cycles = 0;
  bit          idle_on = 1'b1;

  sorted_interval_overlap_check u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req_type     (req_type),
    .start_time   (start_time),
    .end_time     (end_time),
    .done         (done),
    .overlap_found(overlap_found),
    .status       (status),
    .count_a      (count_a),
    .count_b      (count_b)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("sorted_interval_overlap_check_test NOT OK");
      $finish;
    end
  end

  // ---------------- group model ----------------
  function automatic bit sorts_after(span_t x, span_t y);
    if (x.s != y.s) return x.s > y.s;
    return x.e > y.e;
  endfunction

  function automatic bit insert_span(bit to_b, span_t item);
    span_t       g[DEPTH];
    int unsigned n;
    if (to_b) begin
      g = b_spans;
      n = b_len;
    end else begin
      g = a_spans;
      n = a_len;
    end
    if (n >= DEPTH) return 1'b1;
    while (n > 0 && sorts_after(g[n-1], item)) begin
      g[n] = g[n-1];
      n--;
    end
    g[n] = item;
    if (to_b) begin
      b_spans = g;
      b_len++;
    end else begin
      a_spans = g;
      a_len++;
    end
    return 1'b0;
  endfunction

  function automatic bit groups_overlap();
    int unsigned ia;
    int unsigned ib;
    ia = 0;
    ib = 0;
    if (a_len == 0 || b_len == 0) return 1'b0;
    while (ia < a_len && ib < b_len) begin
      if (!(a_spans[ia].e <= b_spans[ib].s || a_spans[ia].s >= b_spans[ib].e))
        return 1'b1;
      if (a_spans[ia].s > b_spans[ib].s) ib++;
      else ia++;
    end
    return 1'b0;
  endfunction

  function automatic outcome_t predict_outcome(sioc_pkg::req_t r, logic [TW-1:0] s,
                                               logic [TW-1:0] e);
    outcome_t o;
    span_t    item;
    item = '{s: s, e: e};
    o.hit = 1'b0;
    o.dropped = 1'b0;
    case (r)
      sioc_pkg::REQ_LOAD_A: o.dropped = insert_span(1'b0, item);
      sioc_pkg::REQ_LOAD_B: o.dropped = insert_span(1'b1, item);
      sioc_pkg::REQ_CLEAR: begin
        a_len = 0;
        b_len = 0;
      end
      default: o.hit = groups_overlap();
    endcase
    o.na = a_len[CW-1:0];
    o.nb = b_len[CW-1:0];
    return o;
  endfunction

  // ---------------- result checking ----------------
  task automatic check_field(string tag, logic [CW-1:0] want, logic [CW-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, tag, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk) begin
    outcome_t w;
    if (!rst && done) begin
      if (outcome_q.size() == 0) begin
        $display("%0t: result with no transaction pending, expected none, got %0d %0d %0d %0d",
                 $time, overlap_found, status, count_a, count_b);
        err_count++;
      end else begin
        w = outcome_q.pop_front();
        check_field("overlap_found", CW'(w.hit), CW'(overlap_found));
        check_field("status", CW'(w.dropped), CW'(status));
        check_field("count_a", w.na, count_a);
        check_field("count_b", w.nb, count_b);
      end
    end
  end

  // ---------------- stimulus ----------------
  task automatic send_item(sioc_pkg::req_t r, logic [TW-1:0] s, logic [TW-1:0] e);
    int unsigned gap;
    @(negedge clk);
    if (idle_on && $urandom_range(99) < 27) begin
      start <= 1'b0;
      gap = $urandom_range(1, 5);
      repeat (gap) @(negedge clk);
    end
    start      <= 1'b1;
    req_type   <= r;
    start_time <= s;
    end_time   <= e;
    do @(posedge clk); while (busy);
    outcome_q.push_back(predict_outcome(r, s, e));
    items_sent++;
  endtask

  // sender holds off until every pending result is back
  task automatic hold_off();
    @(negedge clk);
    start <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk);
  endtask

  function automatic span_t rand_span();
    span_t       sp;
    int unsigned mode;
    mode = $urandom_range(9);
    sp.s = TW'($urandom_range(0, 255));
    if (mode <= 5) begin
      sp.e = sp.s + TW'($urandom_range(0, 40));
    end else if (mode <= 7) begin
      sp.s = TW'($urandom);
      sp.e = TW'($urandom);
    end else if (mode == 8) begin
      sp.e = sp.s - TW'($urandom_range(1, 30));
    end else begin
      sp.e = sp.s;
    end
    return sp;
  endfunction

  task automatic test_empty_groups();
    send_item(sioc_pkg::REQ_QUERY, 16'hFFFF, 16'h0000);
    send_item(sioc_pkg::REQ_CLEAR, 16'h0000, 16'hFFFF);
    send_item(sioc_pkg::REQ_LOAD_A, 16'd10, 16'd20);
    send_item(sioc_pkg::REQ_QUERY, 16'd0, 16'd0);
    send_item(sioc_pkg::REQ_CLEAR, 16'h5555, 16'hAAAA);
    send_item(sioc_pkg::REQ_LOAD_B, 16'd10, 16'd20);
    send_item(sioc_pkg::REQ_QUERY, 16'hAAAA, 16'h5555);
  endtask

  task automatic test_overlap_rules();
    // touching intervals do not overlap
    send_item(sioc_pkg::REQ_LOAD_A, 16'd30, 16'd40);
    send_item(sioc_pkg::REQ_LOAD_B, 16'd40, 16'd50);
    send_item(sioc_pkg::REQ_QUERY, 16'd0, 16'd0);
    send_item(sioc_pkg::REQ_LOAD_A, 16'd30, 16'd45);
    send_item(sioc_pkg::REQ_QUERY, 16'd0, 16'd0);
    send_item(sioc_pkg::REQ_CLEAR, 16'd0, 16'd0);
    // equal keys, inverted and empty intervals, extremes
    send_item(sioc_pkg::REQ_LOAD_A, 16'hFFFF, 16'h0000);
    send_item(sioc_pkg::REQ_LOAD_A, 16'hFFFF, 16'h0000);
    send_item(sioc_pkg::REQ_LOAD_B, 16'd100, 16'd100);
    send_item(sioc_pkg::REQ_LOAD_B, 16'h0000, 16'hFFFF);
    send_item(sioc_pkg::REQ_QUERY, 16'd0, 16'd0);
    send_item(sioc_pkg::REQ_LOAD_A, 16'h0000, 16'hFFFF);
    send_item(sioc_pkg::REQ_LOAD_A, 16'd5, 16'd6);
    send_item(sioc_pkg::REQ_QUERY, 16'hFFFF, 16'hFFFF);
    send_item(sioc_pkg::REQ_CLEAR, 16'hFFFF, 16'hFFFF);
    // equal starts: the walk moves A on
    send_item(sioc_pkg::REQ_LOAD_A, 16'd200, 16'd200);
    send_item(sioc_pkg::REQ_LOAD_B, 16'd200, 16'd210);
    send_item(sioc_pkg::REQ_QUERY, 16'd0, 16'd0);
  endtask

  task automatic test_full_groups();
    span_t sp;
    send_item(sioc_pkg::REQ_CLEAR, TW'($urandom), TW'($urandom));
    repeat (DEPTH + 2) begin
      sp = rand_span();
      send_item(sioc_pkg::REQ_LOAD_A, sp.s, sp.e);
    end
    send_item(sioc_pkg::REQ_QUERY, TW'($urandom), TW'($urandom));
    repeat (DEPTH + 2) begin
      sp = rand_span();
      send_item(sioc_pkg::REQ_LOAD_B, sp.s, sp.e);
    end
    send_item(sioc_pkg::REQ_QUERY, TW'($urandom), TW'($urandom));
    send_item(sioc_pkg::REQ_CLEAR, TW'($urandom), TW'($urandom));
  endtask

  task automatic test_random_sequences(int unsigned n);
    int unsigned target;
    int unsigned na;
    int unsigned nb;
    span_t       sp;
    target = items_sent + n;
    while (items_sent < target) begin
      if ($urandom_range(2) == 0)
        send_item(sioc_pkg::REQ_CLEAR, TW'($urandom), TW'($urandom));
      na = ($urandom_range(11) == 0) ? $urandom_range(40, 70) : $urandom_range(0, 8);
      nb = ($urandom_range(11) == 0) ? $urandom_range(40, 70) : $urandom_range(0, 8);
      while (na + nb > 0) begin
        sp = rand_span();
        if (nb == 0 || (na > 0 && $urandom_range(1) == 0)) begin
          send_item(sioc_pkg::REQ_LOAD_A, sp.s, sp.e);
          na--;
        end else begin
          send_item(sioc_pkg::REQ_LOAD_B, sp.s, sp.e);
          nb--;
        end
        if ($urandom_range(5) == 0)
          send_item(sioc_pkg::REQ_QUERY, TW'($urandom), TW'($urandom));
      end
      send_item(sioc_pkg::REQ_QUERY, TW'($urandom), TW'($urandom));
      if ($urandom_range(9) == 0)
        send_item(sioc_pkg::req_t'($urandom_range(3)), TW'($urandom), TW'($urandom));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_empty_groups();
    test_overlap_rules();
    test_full_groups();
    test_random_sequences(350);
    hold_off();
    idle_on = 1'b0;
    test_random_sequences(250);
    idle_on = 1'b1;
    test_random_sequences(300);
    hold_off();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("sorted_interval_overlap_check_test OK");
    end else begin
      $display("sorted_interval_overlap_check_test NOT OK");
    end
    $finish;
  end

endmodule
